/* rtl/core/acia_register_block_assert.svh */
// Assertion macros shared by the adapter register block RTL.
`ifndef ACIA_REGISTER_BLOCK_ASSERT_SVH
`define ACIA_REGISTER_BLOCK_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on clk and held off while rst_n is low.
`define ACIA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acia_register_block: implication check failed");

// Next-cycle implication, checked on clk and held off while rst_n is low.
`define ACIA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acia_register_block: next-cycle check failed");

`else

`define ACIA_ASSERT_IMP(lbl, ante, cons)
`define ACIA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/core/acia_pkg.sv */
// Shared types, codes and the baud interval table of the adapter register block.
package acia_pkg;

  // Link and bus operation codes carried in the func field.
  localparam logic [2:0] FUNC_READ    = 3'd0;
  localparam logic [2:0] FUNC_WRITE   = 3'd1;
  localparam logic [2:0] FUNC_TX_DONE = 3'd2;
  localparam logic [2:0] FUNC_RX      = 3'd3;
  localparam logic [2:0] FUNC_CARRIER = 3'd4;

  // Register offsets.
  localparam logic [2:0] ADDR_DATA     = 3'd0;
  localparam logic [2:0] ADDR_STATUS   = 3'd1;
  localparam logic [2:0] ADDR_COMMAND  = 3'd2;
  localparam logic [2:0] ADDR_CONTROL  = 3'd3;
  localparam logic [2:0] ADDR_ENHANCED = 3'd7;

  // Configuration register indexes.
  localparam logic CFG_STATUS_DEFAULT  = 1'b0;
  localparam logic CFG_COMMAND_DEFAULT = 1'b1;

  // Status bit positions.
  localparam int ST_RX_FULL  = 3;
  localparam int ST_TX_EMPTY = 4;
  localparam int ST_DCD_LOST = 5;
  localparam int ST_IRQ      = 7;

  // Enhanced speed code that leaves the interval alone.
  localparam logic [1:0] ENH_RESERVED = 2'd3;

  // Reset values.
  localparam logic [7:0]  STATUS_RESET   = 8'd16;
  localparam logic [7:0]  COMMAND_RESET  = 8'd0;
  localparam logic [7:0]  CONTROL_RESET  = 8'd8;
  localparam logic [7:0]  ENHANCED_RESET = 8'd3;
  localparam logic [16:0] INTERVAL_RESET = 17'd3284;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] address;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
    logic       carrier;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        read_valid;
    logic [7:0]  tx_byte;
    logic        tx_pending;
    logic        irq_flag;
    logic [16:0] rx_interval;
  } result_t;

  // Receive interval per baud index: floor(7882000 / baud).
  function automatic logic [16:0] interval_of(input logic [4:0] idx);
    logic [16:0] val;
    case (idx)
      5'd0:    val = 17'd3284;
      5'd1:    val = 17'd78820;
      5'd2:    val = 17'd52546;
      5'd3:    val = 17'd35990;
      5'd4:    val = 17'd29301;
      5'd5:    val = 17'd26273;
      5'd6:    val = 17'd13136;
      5'd7:    val = 17'd6568;
      5'd8:    val = 17'd3284;
      5'd9:    val = 17'd2189;
      5'd10:   val = 17'd1642;
      5'd11:   val = 17'd1094;
      5'd12:   val = 17'd821;
      5'd13:   val = 17'd547;
      5'd14:   val = 17'd410;
      5'd15:   val = 17'd205;
      5'd16:   val = 17'd136;
      5'd17:   val = 17'd68;
      5'd18:   val = 17'd34;
      default: val = 17'd3284;
    endcase
    return val;
  endfunction

endpackage

/* rtl/core/acia_in_if.sv */
// Input word channel: bus accesses and link events.
interface acia_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [2:0] address;
  logic [7:0] write_data;
  logic [7:0] rx_byte;
  logic       carrier;

  modport source(output valid, func, address, write_data, rx_byte, carrier, input ready);
  modport sink(input valid, func, address, write_data, rx_byte, carrier, output ready);
endinterface

/* rtl/core/acia_out_if.sv */
// Result word channel: read data and adapter status.
interface acia_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        read_valid;
  logic [7:0]  tx_byte;
  logic        tx_pending;
  logic        irq_flag;
  logic [16:0] rx_interval;

  modport source(output valid, read_data, read_valid, tx_byte, tx_pending, irq_flag,
                 rx_interval, input ready);
  modport sink(input valid, read_data, read_valid, tx_byte, tx_pending, irq_flag,
               rx_interval, output ready);
endinterface

/* rtl/core/acia_regs.sv */
// Register file and next-state logic of the adapter; forms each result word.
module acia_regs
  import acia_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       acc,
  input  item_t      item,
  output result_t    res
);

  logic [7:0]  status_r,   status_nxt;
  logic [7:0]  command_r,  command_nxt;
  logic [7:0]  control_r,  control_nxt;
  logic [7:0]  enhanced_r, enhanced_nxt;
  logic [7:0]  tx_r,       tx_nxt;
  logic [7:0]  rx_r,       rx_nxt;
  logic [16:0] interval_r, interval_nxt;
  logic [7:0]  cmd_dflt_r;

  logic        derive;
  logic [3:0]  code;
  logic [1:0]  enh;
  logic [4:0]  idx;
  logic [7:0]  rdata;
  logic        rvalid;

  always_comb begin
    status_nxt   = status_r;
    command_nxt  = command_r;
    control_nxt  = control_r;
    enhanced_nxt = enhanced_r;
    tx_nxt       = tx_r;
    rx_nxt       = rx_r;
    derive       = 1'b0;
    code         = control_r[3:0];
    enh          = enhanced_r[1:0];
    rdata        = 8'd0;
    rvalid       = 1'b0;

    case (item.func)
      FUNC_READ: begin
        rvalid = 1'b1;
        unique case (item.address)
          ADDR_DATA: begin
            rdata                = rx_r;
            status_nxt[ST_RX_FULL] = 1'b0;
            status_nxt[ST_IRQ]     = 1'b0;
          end
          ADDR_STATUS:  rdata = status_r;
          ADDR_COMMAND: rdata = command_r;
          ADDR_CONTROL: rdata = control_r;
          ADDR_ENHANCED: begin
            enhanced_nxt[2] = (control_r[3:0] == 4'd0);
            rdata           = enhanced_nxt;
          end
          default: rvalid = 1'b0;
        endcase
      end
      FUNC_WRITE: begin
        unique case (item.address)
          ADDR_DATA: begin
            tx_nxt                  = item.write_data;
            status_nxt[ST_TX_EMPTY] = 1'b0;
          end
          ADDR_STATUS:  command_nxt = cmd_dflt_r;
          ADDR_COMMAND: command_nxt = item.write_data;
          ADDR_CONTROL: begin
            control_nxt = item.write_data;
            code        = item.write_data[3:0];
            derive      = 1'b1;
          end
          ADDR_ENHANCED: begin
            enhanced_nxt = item.write_data;
            enh          = item.write_data[1:0];
            derive       = 1'b1;
          end
          default: ;
        endcase
      end
      FUNC_TX_DONE: status_nxt[ST_TX_EMPTY] = 1'b1;
      FUNC_RX: begin
        rx_nxt                 = item.rx_byte;
        status_nxt[ST_RX_FULL] = 1'b1;
        status_nxt[ST_IRQ]     = 1'b1;
      end
      FUNC_CARRIER: status_nxt[ST_DCD_LOST] = ~item.carrier;
      default: ;
    endcase

    // Control code zero hands the choice to the enhanced speed code.
    idx = {1'b0, code};
    if (code == 4'd0) begin
      case (enh)
        2'd0:    idx = 5'd18;
        2'd1:    idx = 5'd17;
        2'd2:    idx = 5'd16;
        default: idx = 5'd0;
      endcase
    end
    interval_nxt = interval_r;
    if (derive && !(code == 4'd0 && enh == ENH_RESERVED)) begin
      interval_nxt = interval_of(idx);
    end

    res.read_data   = rdata;
    res.read_valid  = rvalid;
    res.tx_byte     = tx_nxt;
    res.tx_pending  = ~status_nxt[ST_TX_EMPTY];
    res.irq_flag    = status_nxt[ST_IRQ];
    res.rx_interval = interval_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r   <= STATUS_RESET;
      command_r  <= COMMAND_RESET;
      control_r  <= CONTROL_RESET;
      enhanced_r <= ENHANCED_RESET;
      tx_r       <= 8'd0;
      rx_r       <= 8'd0;
      interval_r <= INTERVAL_RESET;
      cmd_dflt_r <= COMMAND_RESET;
    end else begin
      if (acc) begin
        status_r   <= status_nxt;
        command_r  <= command_nxt;
        control_r  <= control_nxt;
        enhanced_r <= enhanced_nxt;
        tx_r       <= tx_nxt;
        rx_r       <= rx_nxt;
        interval_r <= interval_nxt;
      end
      // The status default only matters at reset, which always reloads
      // its reset value, so only the command default is kept.
      if (cfg_we && cfg_index == CFG_COMMAND_DEFAULT) begin
        cmd_dflt_r <= cfg_wdata;
      end
    end
  end

endmodule

/* rtl/core/acia_outq.sv */
// Two-entry result queue: a head register and a skid register.
module acia_outq
  import acia_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    not_full,
  output logic    not_empty,
  output result_t head
);

  logic [1:0] cnt_r, cnt_nxt;
  result_t    head_r;
  result_t    skid_r;

  assign not_full  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = head_r;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_r == 2'd2) begin
      if (pop) begin
        head_r <= skid_r;
      end
    end else if (push) begin
      if (cnt_r == 2'd0 || pop) begin
        head_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end
  end

endmodule

/* rtl/core/acia_register_block.sv */
// Top level of the 6551-style adapter register block with turbo speed extension.
//
//   Channel  Direction  Words carried
//   in_ch    sink       bus read/write or link event: func, address, data, rx byte, carrier
//   out_ch   source     read data, read valid, tx byte, tx pending, irq, rx interval
//   cfg_*    write      command default register; the status default index is ignored
//
// Every input word is handled at its accepting edge: the register file updates there
// and the result word is captured into a two-entry output queue.
// One word per cycle is sustained while the output queue has a free entry.
// in_ch.ready drops only when both queue entries hold undelivered results, so a
// stalled sink costs at most two words of slack before the input side waits.
// Reset (rst_n low, synchronous) loads the register file with its reset values and
// empties the queue; configuration writes take effect at the edge they are seen.
`include "acia_register_block_assert.svh"

module acia_register_block
  import acia_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  acia_in_if.sink     in_ch,
  acia_out_if.source  out_ch
);

  logic    in_acc;
  logic    out_acc;
  logic    q_not_full;
  logic    q_not_empty;
  item_t   item;
  result_t res;
  result_t head;

  // Input side is ready whenever the output queue has a free entry.
  assign in_ch.ready = q_not_full;
  assign in_acc      = in_ch.valid & q_not_full;
  assign out_acc     = q_not_empty & out_ch.ready;

  assign item.func       = in_ch.func;
  assign item.address    = in_ch.address;
  assign item.write_data = in_ch.write_data;
  assign item.rx_byte    = in_ch.rx_byte;
  assign item.carrier    = in_ch.carrier;

  acia_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (in_acc),
    .item      (item),
    .res       (res)
  );

  acia_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (res),
    .pop       (out_acc),
    .not_full  (q_not_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  assign out_ch.valid       = q_not_empty;
  assign out_ch.read_data   = head.read_data;
  assign out_ch.read_valid  = head.read_valid;
  assign out_ch.tx_byte     = head.tx_byte;
  assign out_ch.tx_pending  = head.tx_pending;
  assign out_ch.irq_flag    = head.irq_flag;
  assign out_ch.rx_interval = head.rx_interval;

  // Every accepted word leaves a result behind in the queue.
  `ACIA_ASSERT_NEXT(a_accept_gives_result, in_acc, out_ch.valid)
  // A status read into an empty queue shows up next cycle as a valid read.
  `ACIA_ASSERT_NEXT(a_status_read_valid,
    in_acc && !q_not_empty && in_ch.func == FUNC_READ && in_ch.address == ADDR_STATUS,
    out_ch.read_valid)
  // A receive delivery into an empty queue raises the interrupt flag.
  `ACIA_ASSERT_NEXT(a_rx_sets_irq,
    in_acc && !q_not_empty && in_ch.func == FUNC_RX,
    out_ch.irq_flag)

endmodule

/* bench/tb.sv */
// Self-checking testbench for the serial adapter register block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import acia_pkg::*;

  // Receive clock times eight; the pacing interval is this over the baud rate.
  localparam int unsigned CLOCK_X8 = 985250 * 8;
  // Enhanced codes 0..2 select the three turbo entries counting down from this index.
  localparam int unsigned TURBO_TOP = 18;
  localparam int RANDOM_WORDS     = 950;
  localparam int PHASES           = 4;
  localparam int SINK_HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int PRINT_LIMIT      = 100;

  // Shadow copy of the register file. Every accepted input word is applied to it
  // and the result word it must produce is queued; result words are checked in order.
  class adapter_register_shadow;
    logic [7:0]  status_dflt  = STATUS_RESET;
    logic [7:0]  command_dflt = COMMAND_RESET;
    logic [7:0]  status_q     = STATUS_RESET;
    logic [7:0]  command_q    = COMMAND_RESET;
    logic [7:0]  control_q    = CONTROL_RESET;
    logic [7:0]  enhanced_q   = ENHANCED_RESET;
    logic [7:0]  tx_q         = 8'h00;
    logic [7:0]  rx_q         = 8'h00;
    logic [16:0] interval_q   = INTERVAL_RESET;
    int unsigned baud_by_code[19] = '{2400, 100, 150, 219, 269, 300, 600, 1200, 2400,
                                      3600, 4800, 7200, 9600, 14400, 19200, 38400,
                                      57600, 115200, 230400};
    result_t     expected_words[$];
    int          mismatches = 0;

    function void set_config(input logic idx, input logic [7:0] value);
      if (idx == CFG_STATUS_DEFAULT) begin
        status_dflt = value;
      end else begin
        command_dflt = value;
      end
    endfunction

    // A zero baud code in the control register hands over to the enhanced code;
    // the reserved enhanced code leaves the interval where it was.
    function void rederive_interval();
      int unsigned code;
      code = control_q[3:0];
      if (code == 0) begin
        if (enhanced_q[1:0] == ENH_RESERVED) return;
        code = TURBO_TOP - enhanced_q[1:0];
      end
      interval_q = 17'(CLOCK_X8 / baud_by_code[code]);
    endfunction

    function void note_word(input item_t w);
      result_t r;
      r = '0;
      case (w.func)
        FUNC_READ: begin
          r.read_valid = 1'b1;
          case (w.address)
            ADDR_DATA: begin
              r.read_data = rx_q;
              status_q[ST_RX_FULL] = 1'b0;
              status_q[ST_IRQ] = 1'b0;
            end
            ADDR_STATUS:  r.read_data = status_q;
            ADDR_COMMAND: r.read_data = command_q;
            ADDR_CONTROL: r.read_data = control_q;
            ADDR_ENHANCED: begin
              enhanced_q[2] = (control_q[3:0] == 4'h0);
              r.read_data = enhanced_q;
            end
            default: r.read_valid = 1'b0;
          endcase
        end
        FUNC_WRITE: begin
          case (w.address)
            ADDR_DATA: begin
              tx_q = w.write_data;
              status_q[ST_TX_EMPTY] = 1'b0;
            end
            ADDR_STATUS:  command_q = command_dflt;
            ADDR_COMMAND: command_q = w.write_data;
            ADDR_CONTROL: begin
              control_q = w.write_data;
              rederive_interval();
            end
            ADDR_ENHANCED: begin
              enhanced_q = w.write_data;
              rederive_interval();
            end
            default: ;
          endcase
        end
        FUNC_TX_DONE: status_q[ST_TX_EMPTY] = 1'b1;
        FUNC_RX: begin
          rx_q = w.rx_byte;
          status_q[ST_RX_FULL] = 1'b1;
          status_q[ST_IRQ] = 1'b1;
        end
        FUNC_CARRIER: status_q[ST_DCD_LOST] = !w.carrier;
        default: ;
      endcase
      r.tx_byte     = tx_q;
      r.tx_pending  = !status_q[ST_TX_EMPTY];
      r.irq_flag    = status_q[ST_IRQ];
      r.rx_interval = interval_q;
      expected_words.push_back(r);
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("[%0t] result check: %s", $time, msg);
    endtask

    task compare_field(input string name, input logic [16:0] got, input logic [16:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    task check_word(input result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        report_mismatch("result word arrived with nothing expected");
        return;
      end
      want = expected_words.pop_front();
      compare_field("read_data", 17'(got.read_data), 17'(want.read_data));
      compare_field("read_valid", 17'(got.read_valid), 17'(want.read_valid));
      compare_field("tx_byte", 17'(got.tx_byte), 17'(want.tx_byte));
      compare_field("tx_pending", 17'(got.tx_pending), 17'(want.tx_pending));
      compare_field("irq_flag", 17'(got.irq_flag), 17'(want.irq_flag));
      compare_field("rx_interval", got.rx_interval, want.rx_interval);
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;

  // Set by the stimulus to ask the result side for one long hold-off.
  bit sink_hold_req = 1'b0;
  // While set, neither side idles.
  bit calm = 1'b0;

  adapter_register_shadow shadow = new();

  acia_in_if  in_ch();
  acia_out_if out_ch();

  acia_register_block dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both channels are sampled at the rising edge, before any of this edge's
  // nonblocking updates land, so the handshake seen here is the one the block saw.
  // An input word is applied to the shadow before the result check of the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        shadow.note_word(item_t'{in_ch.func, in_ch.address, in_ch.write_data,
                                 in_ch.rx_byte, in_ch.carrier});
      end
      if (out_ch.valid && out_ch.ready) begin
        shadow.check_word(result_t'{out_ch.read_data, out_ch.read_valid, out_ch.tx_byte,
                                    out_ch.tx_pending, out_ch.irq_flag, out_ch.rx_interval});
      end
    end
  end

  // Result side. It stalls at random with a chance of about 15 in 100, never during a calm
  // stretch, and on request holds off for a long stretch that it counts itself so
  // that the output queue fills and the block stops taking input words.
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 15);
      end
    end
  end

  // The run stops here if the traffic ever wedges.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic item_t word_of(input logic [2:0] func, input logic [2:0] address,
                                    input logic [7:0] write_data, input logic [7:0] rx_byte,
                                    input logic carrier);
    return item_t'{func, address, write_data, rx_byte, carrier};
  endfunction

  // Offers one word and holds it until the block takes it. Valid stays high on
  // return so that a following word goes out back to back.
  task automatic send_word(input item_t w);
    in_ch.valid      <= 1'b1;
    in_ch.func       <= w.func;
    in_ch.address    <= w.address;
    in_ch.write_data <= w.write_data;
    in_ch.rx_byte    <= w.rx_byte;
    in_ch.carrier    <= w.carrier;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Random idle gap on the input side.
  task automatic sender_gap();
    if (!calm && $urandom_range(99) < 15) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Stops offering and waits for every outstanding result word, then lets the pipeline go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (shadow.expected_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    shadow.set_config(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [2:0] random_address();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 3'($urandom_range(int'(ADDR_ENHANCED) - 1, int'(ADDR_CONTROL) + 1));
    case ($urandom_range(4))
      0:       return ADDR_DATA;
      1:       return ADDR_STATUS;
      2:       return ADDR_COMMAND;
      3:       return ADDR_CONTROL;
      default: return ADDR_ENHANCED;
    endcase
  endfunction

  // Mostly bus reads and writes, then link events, with a few words carrying
  // unused operation codes. Every field is random on every word.
  function automatic item_t random_word();
    item_t w;
    int pick;
    w.address    = random_address();
    w.write_data = 8'($urandom);
    w.rx_byte    = 8'($urandom);
    w.carrier    = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 28) w.func = FUNC_READ;
    else if (pick < 58) w.func = FUNC_WRITE;
    else if (pick < 70) w.func = FUNC_TX_DONE;
    else if (pick < 82) w.func = FUNC_RX;
    else if (pick < 92) w.func = FUNC_CARRIER;
    else w.func = 3'($urandom_range(7, int'(FUNC_CARRIER) + 1));
    // A zero baud code hands the interval to the enhanced register, so it is
    // made far more likely than a uniform byte would make it.
    if (w.func == FUNC_WRITE && w.address == ADDR_CONTROL && $urandom_range(3) == 0) begin
      w.write_data[3:0] = 4'h0;
    end
    return w;
  endfunction

  task automatic run_directed();
    send_word(word_of(FUNC_READ, ADDR_DATA, 8'h00, 8'h00, 1'b0));
    send_word(word_of(FUNC_READ, ADDR_STATUS, 8'h00, 8'h00, 1'b0));
    send_word(word_of(FUNC_READ, ADDR_COMMAND, 8'h00, 8'h00, 1'b0));
    send_word(word_of(FUNC_READ, ADDR_CONTROL, 8'h00, 8'h00, 1'b0));
    // Control holds a nonzero baud code, so the enhanced read clears bit 2.
    send_word(word_of(FUNC_READ, ADDR_ENHANCED, 8'h00, 8'h00, 1'b0));
    // A read of an undefined offset returns nothing valid.
    send_word(word_of(FUNC_READ, ADDR_CONTROL + 3'd1, 8'hFF, 8'hFF, 1'b1));
    send_word(word_of(FUNC_WRITE, ADDR_DATA, 8'hFF, 8'h00, 1'b0));
    send_word(word_of(FUNC_READ, ADDR_STATUS, 8'h00, 8'h00, 1'b0));
    send_word(word_of(FUNC_TX_DONE, ADDR_DATA, 8'h00, 8'h00, 1'b0));
    send_word(word_of(FUNC_RX, ADDR_DATA, 8'h00, 8'hFF, 1'b0));
    // The data read hands back the received byte and drops the interrupt.
    send_word(word_of(FUNC_READ, ADDR_DATA, 8'h00, 8'h00, 1'b0));
    send_word(word_of(FUNC_RX, ADDR_DATA, 8'h00, 8'h00, 1'b0));
    send_word(word_of(FUNC_CARRIER, ADDR_DATA, 8'h00, 8'h00, 1'b0));
    send_word(word_of(FUNC_CARRIER, ADDR_DATA, 8'h00, 8'h00, 1'b1));
    send_word(word_of(FUNC_WRITE, ADDR_COMMAND, 8'hFF, 8'h00, 1'b0));
    // A status write puts the configured default into the command register.
    send_word(word_of(FUNC_WRITE, ADDR_STATUS, 8'h00, 8'h00, 1'b0));
    // Zero baud code with the reserved enhanced code: the interval stays put.
    send_word(word_of(FUNC_WRITE, ADDR_CONTROL, 8'h00, 8'h00, 1'b0));
    send_word(word_of(FUNC_WRITE, ADDR_ENHANCED, 8'h00, 8'h00, 1'b0));
    send_word(word_of(FUNC_READ, ADDR_ENHANCED, 8'h00, 8'h00, 1'b0));
    send_word(word_of(FUNC_WRITE, ADDR_ENHANCED, 8'h01, 8'h00, 1'b0));
    send_word(word_of(FUNC_WRITE, ADDR_ENHANCED, 8'hFE, 8'h00, 1'b0));
    // Slowest rate gives the largest interval; code 15 is the fastest the control code selects.
    send_word(word_of(FUNC_WRITE, ADDR_CONTROL, 8'h01, 8'h00, 1'b0));
    send_word(word_of(FUNC_WRITE, ADDR_CONTROL, 8'hFF, 8'h00, 1'b0));
    send_word(word_of(FUNC_WRITE, ADDR_ENHANCED - 3'd1, 8'hFF, 8'hFF, 1'b1));
    send_word(word_of(3'b111, ADDR_ENHANCED, 8'hFF, 8'hFF, 1'b1));
  endtask

  // One phase of random traffic. Phase 1 carries the stretch with no idling on
  // either side; phase 2 carries the long result hold-off and a full pause.
  task automatic run_random(input int words, input int phase);
    int offered;
    item_t w;
    offered = 0;
    while (offered < words) begin
      if (phase == 1) calm = (offered >= 40 && offered < 160);
      if (phase == 2 && offered == 60) sink_hold_req = 1'b1;
      if (phase == 2 && offered == 150) settle();
      sender_gap();
      w = random_word();
      send_word(w);
      offered++;
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] status_pick;
    logic [7:0] command_pick;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_STATUS_DEFAULT;
    cfg_wdata        <= 8'h00;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_READ;
    in_ch.address    <= ADDR_DATA;
    in_ch.write_data <= 8'h00;
    in_ch.rx_byte    <= 8'h00;
    in_ch.carrier    <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_cfg(CFG_COMMAND_DEFAULT, 8'h3C);
    write_cfg(CFG_STATUS_DEFAULT, 8'hC3);
    run_directed();

    // Each phase starts from an idle block with new defaults; the first two
    // phases take the extremes, the rest random values.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          status_pick  = 8'h00;
          command_pick = 8'hFF;
        end
        1: begin
          status_pick  = 8'hFF;
          command_pick = 8'h00;
        end
        default: begin
          status_pick  = 8'($urandom);
          command_pick = 8'($urandom);
        end
      endcase
      write_cfg(CFG_STATUS_DEFAULT, status_pick);
      write_cfg(CFG_COMMAND_DEFAULT, command_pick);
      run_random(RANDOM_WORDS / PHASES, phase);
    end

    settle();
    repeat (4) @(posedge clk);
    if (shadow.expected_words.size() != 0) begin
      shadow.report_mismatch($sformatf("%0d result words never arrived",
                                       shadow.expected_words.size()));
    end
    if (shadow.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/acia_pkg.sv
rtl/core/acia_in_if.sv
rtl/core/acia_out_if.sv
rtl/core/acia_regs.sv
rtl/core/acia_outq.sv
rtl/core/acia_register_block.sv
bench/tb.sv
